/* rtl/lpmf_pkg.sv */
// lpmf_pkg: item types, function codes and sequencer states for the
// length-prefixed message fifo. no dependencies.
package lpmf_pkg;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] data;
    logic [7:0] msg_len;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_data;
    logic        out_last;
    logic        empty_res;
    logic        dropped;
    logic [15:0] drop_count;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WR_HDR_HI,
    S_WR_DATA,
    S_RD_HDR_LO,
    S_RD_HDR_HI,
    S_RD_DATA,
    S_RESULT
  } seq_state_e;

endpackage

/* rtl/length_prefixed_message_fifo.sv */
// length_prefixed_message_fifo: byte ring of length-prefixed messages in one
// single-port ring memory with a registered synchronous read, depends on lpmf_pkg.
// states before RESULT: drops, empties, zero-length pushes and discarded bytes EXEC; stored
// bytes EXEC, WR_DATA; first push EXEC, WR_HDR_HI, WR_DATA; popped bytes EXEC, RD_DATA; first
// pop EXEC, RD_HDR_LO, RD_HDR_HI, RD_DATA (not on a zero header). new items wait for S_IDLE.
// reset: pointers, counts, message state and drop counter clear; ring contents undefined.
module length_prefixed_message_fifo #(
  parameter int RING_BYTES  = 2048,
  parameter int MAX_MESSAGE = 255
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lpmf_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lpmf_pkg::out_item_t  out_item_o
);
  import lpmf_pkg::*;

  localparam int PTR_W     = $clog2(RING_BYTES);
  localparam int CNT_W     = $clog2(RING_BYTES + 1);
  localparam int SUM_W     = $clog2(RING_BYTES + 258);
  localparam int LEN_LIMIT = (MAX_MESSAGE < 255) ? MAX_MESSAGE : 255;

  seq_state_e        state_q, state_d;
  in_item_t          item_q;
  logic [PTR_W-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [7:0]        push_rem_q, push_rem_d, push_len_q, push_len_d;
  logic              push_disc_q, push_disc_d;
  logic [7:0]        pop_rem_q, pop_rem_d, pop_len_q, pop_len_d;
  logic [15:0]       drop_cnt_q, drop_cnt_d;
  logic [7:0]        hdr_lo_q, hdr_lo_d;
  out_item_t         res_q, res_d;
  out_item_t         out_q;
  logic              out_valid_q;

  logic [7:0]        ring_q [RING_BYTES];
  logic [7:0]        ring_rdata_q;
  logic              mem_we, mem_re;
  logic [PTR_W-1:0]  mem_addr;
  logic [7:0]        mem_wdata;

  logic [7:0]        len_clamp;
  logic              push_fits;
  logic [15:0]       hdr_raw;
  logic [7:0]        hdr_len;
  logic              out_load;
  logic              in_accept;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_BYTES - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] release_cnt(input logic [CNT_W-1:0] c,
                                                   input logic [7:0] len);
    logic [SUM_W-1:0] n;
    n = SUM_W'(len) + SUM_W'(2);
    return (SUM_W'(c) >= n) ? CNT_W'(SUM_W'(c) - n) : '0;
  endfunction

  assign in_accept = in_valid_i && (state_q == S_IDLE);
  assign len_clamp = (item_q.msg_len > 8'(LEN_LIMIT)) ? 8'(LEN_LIMIT) : item_q.msg_len;
  assign push_fits = (SUM_W'(cnt_q) + SUM_W'(len_clamp) + SUM_W'(2)) <= SUM_W'(RING_BYTES);
  assign hdr_raw   = {ring_rdata_q, hdr_lo_q};
  assign hdr_len   = (hdr_raw > 16'(LEN_LIMIT)) ? 8'(LEN_LIMIT) : hdr_raw[7:0];
  assign out_load  = (state_q == S_RESULT) && (!out_valid_q || !out_stall_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (item_q.func == FUNC_PUSH) begin
          if (push_rem_q == '0) begin
            if (len_clamp == '0 || !push_fits) state_d = S_RESULT;
            else                               state_d = S_WR_HDR_HI;
          end else if (push_disc_q) begin
            state_d = S_RESULT;
          end else begin
            state_d = S_WR_DATA;
          end
        end else begin
          if (pop_rem_q == '0) begin
            if (cnt_q < CNT_W'(2)) state_d = S_RESULT;
            else                   state_d = S_RD_HDR_LO;
          end else begin
            state_d = S_RD_DATA;
          end
        end
      end
      S_WR_HDR_HI: state_d = S_WR_DATA;
      S_WR_DATA:   state_d = S_RESULT;
      S_RD_HDR_LO: state_d = S_RD_HDR_HI;
      S_RD_HDR_HI: state_d = (hdr_len == '0) ? S_RESULT : S_RD_DATA;
      S_RD_DATA:   state_d = S_RESULT;
      S_RESULT: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    wp_d        = wp_q;
    rp_d        = rp_q;
    cnt_d       = cnt_q;
    push_rem_d  = push_rem_q;
    push_len_d  = push_len_q;
    push_disc_d = push_disc_q;
    pop_rem_d   = pop_rem_q;
    pop_len_d   = pop_len_q;
    drop_cnt_d  = drop_cnt_q;
    hdr_lo_d    = hdr_lo_q;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = wp_q;
    mem_wdata   = item_q.data;
    case (state_q)
      S_EXEC: begin
        res_d = '0;
        if (item_q.func == FUNC_PUSH) begin
          if (push_rem_q == '0) begin
            if (len_clamp != '0) begin
              push_len_d = len_clamp;
              push_rem_d = len_clamp - 8'd1;
              if (!push_fits) begin
                drop_cnt_d    = drop_cnt_q + 16'd1;
                push_disc_d   = (len_clamp != 8'd1);
                res_d.dropped = 1'b1;
              end else begin
                push_disc_d = 1'b0;
                mem_we      = 1'b1;
                mem_wdata   = len_clamp;
                wp_d        = advance(wp_q);
              end
            end
          end else if (push_disc_q) begin
            res_d.dropped = 1'b1;
            push_rem_d    = push_rem_q - 8'd1;
            if (push_rem_q == 8'd1) push_disc_d = 1'b0;
          end else begin
            push_rem_d = push_rem_q - 8'd1;
          end
        end else begin
          if (pop_rem_q == '0) begin
            if (cnt_q < CNT_W'(2)) begin
              res_d.empty_res = 1'b1;
            end else begin
              mem_re   = 1'b1;
              mem_addr = rp_q;
              rp_d     = advance(rp_q);
            end
          end else begin
            pop_rem_d = pop_rem_q - 8'd1;
            mem_re    = 1'b1;
            mem_addr  = rp_q;
            rp_d      = advance(rp_q);
          end
        end
      end
      S_WR_HDR_HI: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        wp_d      = advance(wp_q);
      end
      S_WR_DATA: begin
        mem_we = 1'b1;
        wp_d   = advance(wp_q);
        if (push_rem_q == '0) cnt_d = cnt_q + CNT_W'(push_len_q) + CNT_W'(2);
      end
      S_RD_HDR_LO: begin
        hdr_lo_d = ring_rdata_q;
        mem_re   = 1'b1;
        mem_addr = rp_q;
        rp_d     = advance(rp_q);
      end
      S_RD_HDR_HI: begin
        if (hdr_len == '0) begin
          cnt_d           = release_cnt(cnt_q, 8'd0);
          res_d.empty_res = 1'b1;
        end else begin
          pop_len_d = hdr_len;
          pop_rem_d = hdr_len - 8'd1;
          mem_re    = 1'b1;
          mem_addr  = rp_q;
          rp_d      = advance(rp_q);
        end
      end
      S_RD_DATA: begin
        res_d.out_data = ring_rdata_q;
        if (pop_rem_q == '0) begin
          res_d.out_last = 1'b1;
          cnt_d          = release_cnt(cnt_q, pop_len_q);
        end
      end
      S_RESULT, S_IDLE: begin
      end
      default: begin
      end
    endcase
    res_d.drop_count = drop_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      cnt_q       <= '0;
      push_rem_q  <= '0;
      push_len_q  <= '0;
      push_disc_q <= 1'b0;
      pop_rem_q   <= '0;
      pop_len_q   <= '0;
      drop_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      cnt_q       <= cnt_d;
      push_rem_q  <= push_rem_d;
      push_len_q  <= push_len_d;
      push_disc_q <= push_disc_d;
      pop_rem_q   <= pop_rem_d;
      pop_len_q   <= pop_len_d;
      drop_cnt_q  <= drop_cnt_d;
      if (out_load)         out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) item_q <= in_item_i;
    hdr_lo_q <= hdr_lo_d;
    res_q    <= res_d;
    if (out_load) out_q <= res_q;
  end

  // ring memory, one port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_q[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      ring_rdata_q <= ring_q[mem_addr];
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    SUM_W'(cnt_q) <= SUM_W'(RING_BYTES))
    else $error("committed count above ring size");

  a_one_access : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("two ring accesses in one cycle");

  a_disc_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_disc_q |-> (push_rem_q != '0))
    else $error("discarding with no bytes left");

  a_result_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESULT) |=> out_valid_o)
    else $error("result not presented");

endmodule
